// ----- src/dhcp_option_parser_macros.svh -----
// Assertion macros used by the checker file of the option parser.
`ifndef DHCP_OPTION_PARSER_MACROS_SVH
`define DHCP_OPTION_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset
`define DOP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("option parser check failed");

// Next-cycle implication, disabled in reset
`define DOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("option parser check failed");

`endif

// ----- src/dop_pkg.sv -----
// Shared types and constants of the DHCP option parser.
package dop_pkg;

  // Option codes
  localparam logic [7:0] CODE_PAD    = 8'd0;
  localparam logic [7:0] CODE_SUBNET = 8'd1;
  localparam logic [7:0] CODE_ROUTER = 8'd3;
  localparam logic [7:0] CODE_DNS    = 8'd6;
  localparam logic [7:0] CODE_LEASE  = 8'd51;
  localparam logic [7:0] CODE_SERVER = 8'd54;
  localparam logic [7:0] CODE_END    = 8'd255;

  // Result kinds
  localparam logic [2:0] KIND_SERVER = 3'd0;
  localparam logic [2:0] KIND_LEASE  = 3'd1;
  localparam logic [2:0] KIND_SUBNET = 3'd2;
  localparam logic [2:0] KIND_ROUTER = 3'd3;
  localparam logic [2:0] KIND_DNS    = 3'd4;
  localparam logic [2:0] KIND_END    = 3'd5;

  localparam int KIND_W  = 3;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;

  // Parser phase
  typedef enum logic [3:0] {
    PH_CODE  = 4'b0001,
    PH_LEN   = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  // One input item held in the input register
  typedef struct packed {
    logic [7:0] option_byte;
    logic       start_of_options;
  } in_item_t;

  // One result item from the parse logic
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } res_item_t;

endpackage

// ----- src/dhcp_option_parser.sv -----
// Top level of the DHCP option parser.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_ready  | option_byte, start_of_options
//   out     | out_valid / out_ready| result_kind, result_value, list_index
//
// One byte is taken per cycle while in_ready is high; a byte's result passes the input
// register, then the combinational parse logic, then the result register.
// Bytes that give no result just advance the parser state.
// A stalled sink holds the result register; one more byte waits in the input
// register, then in_ready drops. Synchronous reset returns to awaiting a code.
module dhcp_option_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    option_byte,
  input  logic                          start_of_options,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dop_pkg::KIND_W-1:0]    result_kind,
  output logic [dop_pkg::VALUE_W-1:0]   result_value,
  output logic [dop_pkg::INDEX_W-1:0]   list_index
);
  import dop_pkg::*;

  in_item_t  item;
  res_item_t res;
  logic      room;
  logic      take;
  logic      produce;

  dop_in_stage u_in (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .option_byte      (option_byte),
    .start_of_options (start_of_options),
    .room             (room),
    .take             (take),
    .item             (item)
  );

  dop_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (item),
    .produce (produce),
    .res     (res)
  );

  dop_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .produce      (produce),
    .res          (res),
    .room         (room),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .result_value (result_value),
    .list_index   (list_index)
  );

endmodule

// ----- src/dop_in_stage.sv -----
// Input register of the option parser: holds one item until the parse logic takes it.
module dop_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          option_byte,
  input  logic                start_of_options,
  input  logic                room,
  output logic                take,
  output dop_pkg::in_item_t   item
);
  import dop_pkg::*;

  logic held;

  // Take the held item when the result side has room
  assign take     = held && room;
  assign in_ready = !held || room;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.option_byte      <= option_byte;
      item.start_of_options <= start_of_options;
    end
  end

endmodule

// ----- src/dop_parse.sv -----
// Option record state machine and word assembly of the option parser.
module dop_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  dop_pkg::in_item_t    item,
  output logic                 produce,
  output dop_pkg::res_item_t   res
);
  import dop_pkg::*;

  phase_t      phase, phase_next, phase_eff;
  logic [7:0]  code, code_next, code_eff;
  logic [7:0]  remaining, remaining_next, remaining_eff;
  logic [7:0]  offset, offset_next, offset_eff;
  logic [23:0] partial, partial_next, partial_eff;
  logic [7:0]  b;
  logic [7:0]  remaining_dec;
  logic [31:0] word;

  assign b             = item.option_byte;
  assign remaining_dec = remaining_eff - 8'd1;
  assign word          = {partial_eff, b};

  // Work out next state and result for the held byte
  always_comb begin
    phase_eff     = item.start_of_options ? PH_CODE : phase;
    code_eff      = item.start_of_options ? 8'd0 : code;
    remaining_eff = item.start_of_options ? 8'd0 : remaining;
    offset_eff    = item.start_of_options ? 8'd0 : offset;
    partial_eff   = item.start_of_options ? 24'd0 : partial;

    phase_next     = phase_eff;
    code_next      = code_eff;
    remaining_next = remaining_eff;
    offset_next    = offset_eff;
    partial_next   = partial_eff;
    produce        = 1'b0;
    res.kind       = KIND_END;
    res.value      = '0;
    res.index      = '0;

    unique case (phase_eff)
      PH_CODE: begin
        if (b == CODE_PAD) begin
          phase_next = PH_CODE;
        end else if (b == CODE_END) begin
          produce    = 1'b1;
          phase_next = PH_DONE;
        end else begin
          code_next  = b;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        remaining_next = b;
        offset_next    = 8'd0;
        partial_next   = 24'd0;
        phase_next     = (b != 8'd0) ? PH_VALUE : PH_CODE;
      end
      PH_VALUE: begin
        if (offset_eff[1:0] != 2'd3) begin
          partial_next = {partial_eff[15:0], b};
        end else begin
          partial_next = 24'd0;
          res.value    = word;
          if (offset_eff[7:2] == '0 && code_eff == CODE_SERVER) begin
            produce  = 1'b1;
            res.kind = KIND_SERVER;
          end else if (offset_eff[7:2] == '0 && code_eff == CODE_LEASE) begin
            produce  = 1'b1;
            res.kind = KIND_LEASE;
          end else if (offset_eff[7:2] == '0 && code_eff == CODE_SUBNET) begin
            produce  = 1'b1;
            res.kind = KIND_SUBNET;
          end else if (code_eff == CODE_ROUTER) begin
            produce   = 1'b1;
            res.kind  = KIND_ROUTER;
            res.index = offset_eff[7:2];
          end else if (code_eff == CODE_DNS) begin
            produce   = 1'b1;
            res.kind  = KIND_DNS;
            res.index = offset_eff[7:2];
          end
        end
        offset_next    = offset_eff + 8'd1;
        remaining_next = remaining_dec;
        if (remaining_dec == 8'd0) begin
          phase_next = PH_CODE;
        end
      end
      PH_DONE: begin
        // drop bytes until the next start
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_CODE;
      end
    endcase
  end

  // Advance parser state per taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_CODE;
      code      <= 8'd0;
      remaining <= 8'd0;
      offset    <= 8'd0;
      partial   <= 24'd0;
    end else if (take) begin
      phase     <= phase_next;
      code      <= code_next;
      remaining <= remaining_next;
      offset    <= offset_next;
      partial   <= partial_next;
    end
  end

endmodule

// ----- src/dop_out_stage.sv -----
// Result register of the option parser: holds one result until the sink takes it.
module dop_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic                             produce,
  input  dop_pkg::res_item_t               res,
  output logic                             room,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dop_pkg::KIND_W-1:0]       result_kind,
  output logic [dop_pkg::VALUE_W-1:0]      result_value,
  output logic [dop_pkg::INDEX_W-1:0]      list_index
);
  import dop_pkg::*;

  res_item_t held;

  // Room when empty or the held result leaves this cycle
  assign room = !out_valid || out_ready;

  // Update valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= produce;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (take && produce) begin
      held <= res;
    end
  end

  assign result_kind  = held.kind;
  assign result_value = held.value;
  assign list_index   = held.index;

endmodule

// ----- src/dop_checker.sv -----
// Port-level checks of the DHCP option parser, bound to its top level.
`include "dhcp_option_parser_macros.svh"

module dop_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dop_pkg::KIND_W-1:0]    result_kind,
  input logic [dop_pkg::VALUE_W-1:0]   result_value,
  input logic [dop_pkg::INDEX_W-1:0]   list_index
);
  import dop_pkg::*;

  logic                               stalled;
  logic                               is_end;
  logic                               is_single;
  logic [KIND_W+VALUE_W+INDEX_W-1:0]  payload;

  // Condense the port view for the checks below
  assign stalled   = out_valid && !out_ready;
  assign is_end    = out_valid && (result_kind == KIND_END);
  assign is_single = out_valid && (result_kind inside {KIND_SERVER, KIND_LEASE, KIND_SUBNET});
  assign payload   = {result_kind, result_value, list_index};

  // Stalled result stays offered
  `DOP_ASSERT_NEXT(a_out_hold, clk, rst, stalled, out_valid)

  // Stalled result keeps its payload
  `DOP_ASSERT_NEXT(a_out_stable, clk, rst, stalled, $stable(payload))

  // End result carries zero value and index
  `DOP_ASSERT_NOW(a_end_zero, clk, rst, is_end, result_value == '0 && list_index == '0)

  // Single-value options always report the first word
  `DOP_ASSERT_NOW(a_single_idx, clk, rst, is_single, list_index == '0)

endmodule

bind dhcp_option_parser dop_checker u_dop_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_kind  (result_kind),
  .result_value (result_value),
  .list_index   (list_index)
);
